FILE: rtl/core/irpdd_pkg.sv
// Package for the IR pulse-distance decoder: field widths, class codes,
// register indexes, reset values and the tolerance window check.
// No dependencies.
package irpdd_pkg;

  localparam int unsigned FrameBitsDefault = 32;
  localparam int unsigned TimeW            = 16;
  localparam int unsigned CountW           = 6;
  localparam int unsigned WordW            = 32;
  localparam int unsigned CfgIdxW          = 3;
  localparam int unsigned CfgDataW         = 16;

  localparam logic [TimeW-1:0] TimeWrapped = 16'hFFFF;

  typedef enum logic [2:0] {
    CLASS_IGNORED = 3'd0,
    CLASS_HEADER  = 3'd1,
    CLASS_ONE     = 3'd2,
    CLASS_ZERO    = 3'd3,
    CLASS_ERROR   = 3'd4
  } edge_class_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HEADER_NOM = 3'd0,
    REG_HEADER_TOL = 3'd1,
    REG_ONE_NOM    = 3'd2,
    REG_ONE_TOL    = 3'd3,
    REG_ZERO_NOM   = 3'd4,
    REG_ZERO_TOL   = 3'd5
  } cfg_reg_e;

  localparam logic [TimeW-1:0] HeaderNomReset = 16'd13500;
  localparam logic [TimeW-1:0] HeaderTolReset = 16'd1000;
  localparam logic [TimeW-1:0] OneNomReset    = 16'd2250;
  localparam logic [TimeW-1:0] OneTolReset    = 16'd300;
  localparam logic [TimeW-1:0] ZeroNomReset   = 16'd1125;
  localparam logic [TimeW-1:0] ZeroTolReset   = 16'd300;

  // strict window: |t - nominal| < tolerance
  function automatic logic in_window(logic [TimeW-1:0] t, logic [TimeW-1:0] nominal,
                                     logic [TimeW-1:0] tolerance);
    logic [TimeW-1:0] diff;
    diff = (t >= nominal) ? (t - nominal) : (nominal - t);
    return diff < tolerance;
  endfunction

endpackage

FILE: rtl/core/irpdd_in_if.sv
// Input item channel of the IR pulse-distance decoder.
// Depends on irpdd_pkg.
interface irpdd_in_if
  import irpdd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             action;
  logic [TimeW-1:0] interval;
  logic             timer_wrapped;
  logic             pin_low;

  modport source (output valid, action, interval, timer_wrapped, pin_low, input ready);
  modport sink   (input valid, action, interval, timer_wrapped, pin_low, output ready);
endinterface

FILE: rtl/core/irpdd_out_if.sv
// Result item channel of the IR pulse-distance decoder.
// Depends on irpdd_pkg.
interface irpdd_out_if
  import irpdd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [2:0]        edge_class;
  logic              frame_ready;
  logic              frame_valid;
  logic [7:0]        address_byte;
  logic [7:0]        address_inverse;
  logic [7:0]        command_byte;
  logic [7:0]        command_inverse;
  logic [CountW-1:0] bits_received;

  modport source (output valid, edge_class, frame_ready, frame_valid, address_byte,
                  address_inverse, command_byte, command_inverse, bits_received,
                  input ready);
  modport sink   (input valid, edge_class, frame_ready, frame_valid, address_byte,
                  address_inverse, command_byte, command_inverse, bits_received,
                  output ready);
endinterface

FILE: rtl/core/irpdd_cfg_if.sv
// Configuration write channel of the IR pulse-distance decoder.
// Depends on irpdd_pkg.
interface irpdd_cfg_if
  import irpdd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ir_pulse_distance_decoder_unit.sv
// IR pulse-distance decoder top level (NEC-style remote frames).
// Depends on irpdd_pkg and the irpdd_in_if, irpdd_out_if and irpdd_cfg_if channels.
//
// Usage: each input item is either an edge event (action 0) carrying the ticks
// since the previous falling edge, or a read (action 1) that hands out a pending
// frame and clears the ready flag. Every item yields exactly one result item.
// The block takes one item per clock cycle, sustained. An item is held in the
// input register, then the classify-and-update step writes the result
// register, from which the result item is offered and can be taken when the
// output is not stalled. The rate is set by the single classify-and-shift step,
// which reads and writes the frame state in the same cycle. A stalled output
// holds the result register and back-pressures through the input register.
// Window registers come out of reset at the nominal NEC timings; write them
// only while the block is idle.
// Writes to register indexes past the last window register are dropped.
module ir_pulse_distance_decoder_unit
  import irpdd_pkg::*;
#(
  parameter int unsigned FRAME_BITS = FrameBitsDefault  // 8..32
) (
  input logic          clk_i,
  input logic          rst_ni,
  irpdd_in_if.sink     in_i,
  irpdd_out_if.source  out_o,
  irpdd_cfg_if.sink    cfg_i
);

  // ---------------------------------------------------------------------------
  // Window registers
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] hdr_nom_q, hdr_tol_q, one_nom_q, one_tol_q, zero_nom_q, zero_tol_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_nom_q  <= HeaderNomReset;
      hdr_tol_q  <= HeaderTolReset;
      one_nom_q  <= OneNomReset;
      one_tol_q  <= OneTolReset;
      zero_nom_q <= ZeroNomReset;
      zero_tol_q <= ZeroTolReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_HEADER_NOM: hdr_nom_q  <= cfg_i.data;
        REG_HEADER_TOL: hdr_tol_q  <= cfg_i.data;
        REG_ONE_NOM:    one_nom_q  <= cfg_i.data;
        REG_ONE_TOL:    one_tol_q  <= cfg_i.data;
        REG_ZERO_NOM:   zero_nom_q <= cfg_i.data;
        REG_ZERO_TOL:   zero_tol_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: input register feeds the result register
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic adv_in, adv_out;

  assign adv_out    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv_out;
  assign adv_in     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        s1_valid_q <= 1'b1;
      end else if (adv_out) begin
        s1_valid_q <= 1'b0;
      end
      if (adv_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register (payload, no reset)
  logic             s1_action_q;
  logic [TimeW-1:0] s1_interval_q;
  logic             s1_wrapped_q;
  logic             s1_pin_low_q;

  always_ff @(posedge clk_i) begin
    if (adv_in) begin
      s1_action_q   <= in_i.action;
      s1_interval_q <= in_i.interval;
      s1_wrapped_q  <= in_i.timer_wrapped;
      s1_pin_low_q  <= in_i.pin_low;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state and classification
  // ---------------------------------------------------------------------------
  logic [WordW-1:0]  frame_q, frame_d;
  logic [CountW-1:0] idx_q, idx_d, idx_inc;
  logic              ready_q, ready_d;

  edge_class_e       cls;
  logic              rd_valid;
  logic [WordW-1:0]  rd_word;
  logic [TimeW-1:0]  t;

  assign t       = s1_wrapped_q ? TimeWrapped : s1_interval_q;
  assign idx_inc = idx_q + CountW'(1);

  always_comb begin
    frame_d  = frame_q;
    idx_d    = idx_q;
    ready_d  = ready_q;
    cls      = CLASS_IGNORED;
    rd_valid = 1'b0;
    rd_word  = '0;
    if (s1_action_q) begin
      if (ready_q) begin
        ready_d  = 1'b0;
        rd_valid = 1'b1;
        rd_word  = frame_q;
      end
    end else if (s1_pin_low_q && !ready_q) begin
      if (in_window(t, hdr_nom_q, hdr_tol_q)) begin
        cls     = CLASS_HEADER;
        idx_d   = '0;
        frame_d = '0;
      end else if (in_window(t, one_nom_q, one_tol_q)) begin
        cls                 = CLASS_ONE;
        frame_d[idx_q[4:0]] = 1'b1;
        idx_d               = idx_inc;
      end else if (in_window(t, zero_nom_q, zero_tol_q)) begin
        cls                 = CLASS_ZERO;
        frame_d[idx_q[4:0]] = 1'b0;
        idx_d               = idx_inc;
      end else begin
        cls     = CLASS_ERROR;
        idx_d   = '0;
        frame_d = '0;
      end
      // frame complete: flag it and rewind the count
      if (idx_d >= CountW'(FRAME_BITS)) begin
        ready_d = 1'b1;
        idx_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      idx_q   <= '0;
      ready_q <= 1'b0;
    end else if (adv_out) begin
      frame_q <= frame_d;
      idx_q   <= idx_d;
      ready_q <= ready_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic [2:0]        res_class_q;
  logic              res_ready_q;
  logic              res_valid_q;
  logic [WordW-1:0]  res_word_q;
  logic [CountW-1:0] res_count_q;

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      res_class_q <= cls;
      res_ready_q <= ready_d;
      res_valid_q <= rd_valid;
      res_word_q  <= rd_word;
      res_count_q <= idx_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.edge_class      = res_class_q;
  assign out_o.frame_ready     = res_ready_q;
  assign out_o.frame_valid     = res_valid_q;
  assign out_o.address_byte    = res_word_q[7:0];
  assign out_o.address_inverse = res_word_q[15:8];
  assign out_o.command_byte    = res_word_q[23:16];
  assign out_o.command_inverse = res_word_q[31:24];
  assign out_o.bits_received   = res_count_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // a read never reports an edge class
  a_read_no_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_valid_q |-> res_class_q == CLASS_IGNORED)
    else $error("read result carries an edge class");

  // handing out a frame clears the ready flag
  a_read_clears_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_valid_q |-> !res_ready_q)
    else $error("ready still set after frame read");

  // bit count always below the frame length
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < CountW'(FRAME_BITS))
    else $error("bit count reached frame length");

  // a pending frame freezes the count at zero
  a_ready_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> idx_q == '0)
    else $error("bit count non-zero while frame pending");

  // ready only rises on an item leaving the input register
  a_ready_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(adv_out) && $past(!s1_action_q))
    else $error("ready flag set without an edge item");

endmodule
